>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// implication that is checked through reset as well
`define ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("unconditional check failed");

`endif

>>> hw/rtl/bhp_pkg.sv
// types, codes and helper functions of the bitmap header parser
// no dependencies
package bhp_pkg;

   localparam int unsigned RSP_DATA_W = 208;

   localparam logic [7:0] SIG_B = 8'h42;
   localparam logic [7:0] SIG_M = 8'h4d;

   localparam logic [31:0] HDR_SIZE_CORE = 32'd12;
   localparam logic [31:0] HDR_SIZE_INFO = 32'd40;
   localparam logic [31:0] HDR_SIZE_V4   = 32'd108;
   localparam logic [31:0] HDR_SIZE_V5   = 32'd124;
   localparam logic [7:0]  FILE_HDR_SIZE = 8'd14;

   localparam logic [7:0] POS_SIG_B     = 8'd0;
   localparam logic [7:0] POS_SIG_M     = 8'd1;
   localparam logic [7:0] POS_FILE_SIZE = 8'd5;
   localparam logic [7:0] POS_RSVD_1    = 8'd7;
   localparam logic [7:0] POS_RSVD_2    = 8'd9;
   localparam logic [7:0] POS_OFFSET    = 8'd13;
   localparam logic [7:0] POS_HDR_SIZE  = 8'd17;
   localparam logic [7:0] POS_C_WIDTH   = 8'd19;
   localparam logic [7:0] POS_C_HEIGHT  = 8'd21;
   localparam logic [7:0] POS_C_PLANES  = 8'd23;
   localparam logic [7:0] POS_C_BPP     = 8'd25;
   localparam logic [7:0] POS_I_WIDTH   = 8'd21;
   localparam logic [7:0] POS_I_HEIGHT  = 8'd25;
   localparam logic [7:0] POS_I_PLANES  = 8'd27;
   localparam logic [7:0] POS_I_BPP     = 8'd29;
   localparam logic [7:0] POS_I_COMP    = 8'd33;

   localparam logic [15:0] PLANES_ONE = 16'd1;
   localparam logic [31:0] COMP_RGB       = 32'd0;
   localparam logic [31:0] COMP_BITFIELDS = 32'd3;
   localparam logic [31:0] MIN_GAP        = 32'd4;

   typedef enum logic [3:0] {
      ERR_OK          = 4'd0,
      ERR_SIGNATURE   = 4'd1,
      ERR_RESERVED    = 4'd2,
      ERR_HEADER_SIZE = 4'd3,
      ERR_PLANES      = 4'd4,
      ERR_TOPDOWN     = 4'd5,
      ERR_WIDTH       = 4'd6,
      ERR_OFFSET      = 4'd7,
      ERR_GAP         = 4'd8,
      ERR_QUAD        = 4'd9,
      ERR_TRUNCATED   = 4'd10,
      ERR_COMPRESSION = 4'd11
   } error_code_type;

   typedef enum logic [1:0] {
      KIND_CORE = 2'd0,
      KIND_INFO = 2'd1,
      KIND_V4   = 2'd2,
      KIND_V5   = 2'd3
   } header_kind_type;

   // result item, last field in the lowest bits
   typedef struct packed {
      logic [7:0]      palette_blue;
      logic [7:0]      palette_green;
      logic [7:0]      palette_red;
      logic            zero_size_warning;
      logic [31:0]     declared_file_size;
      logic [31:0]     pixel_offset;
      logic [31:0]     compression_code;
      logic [15:0]     bits_per_pixel;
      logic [31:0]     image_height;
      logic [31:0]     image_width;
      header_kind_type header_kind;
      error_code_type  error_code;
   } result_type;

   function automatic logic compression_ok(input logic [31:0] comp);
      return (comp <= 32'd5) || (comp == 32'd11) || (comp == 32'd12) || (comp == 32'd13);
   endfunction

   function automatic logic header_size_ok(input logic [31:0] hs);
      return (hs == HDR_SIZE_CORE) || (hs == HDR_SIZE_INFO) ||
             (hs == HDR_SIZE_V4) || (hs == HDR_SIZE_V5);
   endfunction

   function automatic header_kind_type kind_of(input logic [31:0] hs);
      header_kind_type kind;
      if (hs == HDR_SIZE_CORE) kind = KIND_CORE;
      else if (hs == HDR_SIZE_INFO) kind = KIND_INFO;
      else if (hs == HDR_SIZE_V4) kind = KIND_V4;
      else kind = KIND_V5;
      return kind;
   endfunction

   // byte position just past the info header
   function automatic logic [7:0] header_end(input header_kind_type kind);
      logic [7:0] hend;
      case (kind)
         KIND_CORE: hend = FILE_HDR_SIZE + HDR_SIZE_CORE[7:0];
         KIND_INFO: hend = FILE_HDR_SIZE + HDR_SIZE_INFO[7:0];
         KIND_V4:   hend = FILE_HDR_SIZE + HDR_SIZE_V4[7:0];
         KIND_V5:   hend = FILE_HDR_SIZE + HDR_SIZE_V5[7:0];
         default:   hend = FILE_HDR_SIZE + HDR_SIZE_V5[7:0];
      endcase
      return hend;
   endfunction

endpackage

>>> hw/rtl/bitmap_header_parser_core.sv
// bitmap file header parser, top level
// depends on bhp_pkg
// Takes one file byte per item and accepts an item in every cycle, as long as
// the result register is free or being emptied in the same cycle. Each byte
// updates the field shift register and capture registers in one pass; the one
// result of a file (summary or first error) appears in the result register
// in the cycle after the byte that decides it, and bytes that follow are ignored
// until the item marked tlast, after which the parser rearms for the next file.
module bitmap_header_parser_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // data_byte
   input  logic                              req_tlast,   // end_of_file
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // error_code, header_kind, image_width, image_height, bits_per_pixel,
   // compression_code, pixel_offset, declared_file_size, zero_size_warning,
   // palette_red, palette_green, palette_blue, one zero pad bit
   output logic [bhp_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import bhp_pkg::*;

   logic [7:0]            pos_ff, pos_in;
   logic [31:0]           acc_ff, acc_in;
   header_kind_type       kind_ff, kind_in;
   logic [31:0]           width_ff, width_in;
   logic [31:0]           height_ff, height_in;
   logic [31:0]           size_ff, size_in;
   logic [31:0]           offset_ff, offset_in;
   logic [15:0]           bpp_ff, bpp_in;
   logic [31:0]           comp_ff, comp_in;
   logic [2:0][7:0]       pal_ff, pal_in;
   logic                  done_ff, done_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff, rsp_in;

   logic                  accept;
   logic [31:0]           acc_new;
   logic [15:0]           hi16;
   logic [7:0]            hend;
   logic [31:0]           hend_w;
   logic [31:0]           gap;
   logic [7:0]            pal_pos;
   logic                  topdown;
   logic                  hit;
   error_code_type        code;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign acc_new    = {req_tdata, acc_ff[31:8]};
   assign hi16       = acc_new[31:16];
   assign hend       = header_end(kind_ff);
   assign hend_w     = {24'd0, hend};
   assign gap        = offset_ff - hend_w;
   assign pal_pos    = pos_ff - hend;
   assign topdown    = (height_ff == 32'd0) || height_ff[31];

   always_comb begin
      pos_in    = pos_ff;
      acc_in    = acc_ff;
      kind_in   = kind_ff;
      width_in  = width_ff;
      height_in = height_ff;
      size_in   = size_ff;
      offset_in = offset_ff;
      bpp_in    = bpp_ff;
      comp_in   = comp_ff;
      pal_in    = pal_ff;
      done_in   = done_ff;
      hit       = 1'b0;
      code      = ERR_OK;

      if (!done_ff) begin
         acc_in = acc_new;
         if (pos_ff == POS_SIG_B) begin
            if (req_tdata != SIG_B) begin
               hit  = 1'b1;
               code = ERR_SIGNATURE;
            end
         end else if (pos_ff == POS_SIG_M) begin
            if (req_tdata != SIG_M) begin
               hit  = 1'b1;
               code = ERR_SIGNATURE;
            end
         end else if (pos_ff == POS_FILE_SIZE) begin
            size_in = acc_new;
         end else if (pos_ff == POS_RSVD_1 || pos_ff == POS_RSVD_2) begin
            if (hi16 != 16'd0) begin
               hit  = 1'b1;
               code = ERR_RESERVED;
            end
         end else if (pos_ff == POS_OFFSET) begin
            offset_in = acc_new;
         end else if (pos_ff == POS_HDR_SIZE) begin
            kind_in = kind_of(acc_new);
            if (!header_size_ok(acc_new)) begin
               hit  = 1'b1;
               code = ERR_HEADER_SIZE;
            end
         end else if (pos_ff > POS_HDR_SIZE) begin
            if (kind_ff == KIND_CORE) begin
               if (pos_ff == POS_C_WIDTH) width_in = {16'd0, hi16};
               else if (pos_ff == POS_C_HEIGHT) height_in = {16'd0, hi16};
               else if (pos_ff == POS_C_PLANES) begin
                  if (hi16 != PLANES_ONE) begin
                     hit  = 1'b1;
                     code = ERR_PLANES;
                  end
               end else if (pos_ff == POS_C_BPP) bpp_in = hi16;
            end else begin
               if (pos_ff == POS_I_WIDTH) width_in = acc_new;
               else if (pos_ff == POS_I_HEIGHT) height_in = acc_new;
               else if (pos_ff == POS_I_PLANES) begin
                  if (hi16 != PLANES_ONE) begin
                     hit  = 1'b1;
                     code = ERR_PLANES;
                  end
               end else if (pos_ff == POS_I_BPP) bpp_in = hi16;
               else if (pos_ff == POS_I_COMP) begin
                  comp_in = acc_new;
                  if (!compression_ok(acc_new)) begin
                     hit  = 1'b1;
                     code = ERR_COMPRESSION;
                  end
               end
            end

            if (!hit) begin
               if (pos_ff == hend - 8'd1) begin
                  // header end checks
                  if (topdown && kind_ff != KIND_CORE && comp_ff != COMP_RGB &&
                      comp_ff != COMP_BITFIELDS) begin
                     hit  = 1'b1;
                     code = ERR_TOPDOWN;
                  end else if (width_ff == 32'd0) begin
                     hit  = 1'b1;
                     code = ERR_WIDTH;
                  end else if (offset_ff < hend_w) begin
                     hit  = 1'b1;
                     code = ERR_OFFSET;
                  end else if (gap == 32'd0) begin
                     hit  = 1'b1;
                     code = ERR_OK;
                  end else if (gap < MIN_GAP) begin
                     hit  = 1'b1;
                     code = ERR_GAP;
                  end
               end else if (pos_ff >= hend && pos_ff < hend + 8'd3) begin
                  pal_in[pal_pos[1:0]] = req_tdata;
               end else if (pos_ff == hend + 8'd3) begin
                  hit  = 1'b1;
                  code = (req_tdata != 8'd0) ? ERR_QUAD : ERR_OK;
               end
            end
         end

         if (hit) done_in = 1'b1;
         else pos_in = pos_ff + 8'd1;
      end

      if (req_tlast) begin
         if (!hit && !done_ff) begin
            hit  = 1'b1;
            code = ERR_TRUNCATED;
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.error_code = code;
      if (code == ERR_OK) begin
         rsp_in.header_kind        = kind_in;
         rsp_in.image_width        = width_in;
         rsp_in.image_height       = height_in;
         rsp_in.bits_per_pixel     = bpp_in;
         rsp_in.compression_code   = comp_in;
         rsp_in.pixel_offset       = offset_in;
         rsp_in.declared_file_size = size_in;
         rsp_in.zero_size_warning  = (size_in == 32'd0);
         rsp_in.palette_red        = pal_in[0];
         rsp_in.palette_green      = pal_in[1];
         rsp_in.palette_blue       = pal_in[2];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && hit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         acc_ff       <= '0;
         kind_ff      <= KIND_CORE;
         width_ff     <= '0;
         height_ff    <= '0;
         size_ff      <= '0;
         offset_ff    <= '0;
         bpp_ff       <= '0;
         comp_ff      <= '0;
         pal_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (req_tlast) begin
               pos_ff    <= '0;
               acc_ff    <= '0;
               kind_ff   <= KIND_CORE;
               width_ff  <= '0;
               height_ff <= '0;
               size_ff   <= '0;
               offset_ff <= '0;
               bpp_ff    <= '0;
               comp_ff   <= '0;
               pal_ff    <= '0;
               done_ff   <= 1'b0;
            end else begin
               pos_ff    <= pos_in;
               acc_ff    <= acc_in;
               kind_ff   <= kind_in;
               width_ff  <= width_in;
               height_ff <= height_in;
               size_ff   <= size_in;
               offset_ff <= offset_in;
               bpp_ff    <= bpp_in;
               comp_ff   <= comp_in;
               pal_ff    <= pal_in;
               done_ff   <= done_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hit) rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

endmodule

>>> hw/rtl/bhp_checker.sv
// port-level checks of the bitmap header parser, bound to the top level
// depends on bhp_pkg and assert_macros.svh
`include "assert_macros.svh"

module bhp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [7:0]                        req_tdata,
   input logic                              req_tlast,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [bhp_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import bhp_pkg::*;

   logic           req_accept;
   logic           err_result;
   logic           ok_result;
   logic [3:0]     rsp_code;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_code   = rsp_tdata[3:0];
   assign err_result = rsp_tvalid && (rsp_code != ERR_OK);
   assign ok_result  = rsp_tvalid && (rsp_code == ERR_OK);

   // stalled item holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                rsp_tvalid && $stable(rsp_tdata))

   // an error item carries nothing but its code
   `ASSERT_IMPLIES(a_err_zero, clock, reset, err_result,
                   rsp_tdata[RSP_DATA_W-1:4] == '0)

   // zero size flag follows the declared size
   `ASSERT_IMPLIES(a_zero_size, clock, reset, ok_result,
                   rsp_tdata[182] == (rsp_tdata[181:150] == 32'd0))

   // no item right after reset
   `ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) && !reset, !rsp_tvalid)

   // input can be taken whenever the result register drains
   `ASSERT_IMPLIES(a_ready_free, clock, reset, !rsp_tvalid || rsp_tready,
                   req_tready)

   logic unused_ok;
   assign unused_ok = req_accept ^ req_tlast ^ (^req_tdata);

endmodule

bind bitmap_header_parser_core bhp_checker u_bhp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> verif/tb_bitmap_header_parser_core.sv
// self-checking testbench for bitmap_header_parser_core: streams bitmap files byte by byte
// and checks every summary or error item against an in-bench model of the header parser
// depends on bhp_pkg and bitmap_header_parser_core
module tb_bitmap_header_parser_core;
   import bhp_pkg::*;

   typedef enum int {
      FAULT_HEADER_SIZE,
      FAULT_PLANES,
      FAULT_TOPDOWN,
      FAULT_WIDTH,
      FAULT_OFFSET,
      FAULT_GAP,
      FAULT_QUAD,
      FAULT_COMPRESSION,
      FAULT_SIGNATURE,
      FAULT_RESERVED,
      FAULT_TRUNCATE,
      FAULT_COUNT
   } fault_kind_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;   // data_byte
   logic req_tlast = 1'b0;          // end_of_file
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // error_code, header_kind, image_width, image_height, bits_per_pixel, compression_code,
   // pixel_offset, declared_file_size, zero_size_warning, palette_red/green/blue, pad
   logic [RSP_DATA_W-1:0] rsp_tdata;

   bitmap_header_parser_core dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   // parser model state
   logic [7:0]  parse_pos;
   logic [31:0] shift_acc;
   logic [31:0] hdr_size;
   logic [31:0] cap_width;
   logic [31:0] cap_height;
   logic [31:0] cap_file_size;
   logic [31:0] cap_offset;
   logic [15:0] cap_bpp;
   logic [31:0] cap_comp;
   logic [7:0]  pal_bytes [3];
   logic        parse_done;

   result_type  expected_results [$];
   logic [7:0]  file_bytes [$];
   int          results_predicted = 0;
   int          bytes_sent = 0;
   int          failures = 0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic clear_parser_model();
      parse_pos = '0;
      shift_acc = '0;
      hdr_size = '0;
      cap_width = '0;
      cap_height = '0;
      cap_file_size = '0;
      cap_offset = '0;
      cap_bpp = '0;
      cap_comp = '0;
      pal_bytes = '{default: 8'h00};
      parse_done = 1'b0;
   endtask

   task automatic queue_result(input error_code_type code);
      result_type r;
      r = '0;
      r.error_code = code;
      if (code == ERR_OK) begin
         case (hdr_size)
            HDR_SIZE_CORE: r.header_kind = KIND_CORE;
            HDR_SIZE_INFO: r.header_kind = KIND_INFO;
            HDR_SIZE_V4:   r.header_kind = KIND_V4;
            default:       r.header_kind = KIND_V5;
         endcase
         r.image_width = cap_width;
         r.image_height = cap_height;
         r.bits_per_pixel = cap_bpp;
         r.compression_code = cap_comp;
         r.pixel_offset = cap_offset;
         r.declared_file_size = cap_file_size;
         r.zero_size_warning = (cap_file_size == 32'h0);
         r.palette_red = pal_bytes[0];
         r.palette_green = pal_bytes[1];
         r.palette_blue = pal_bytes[2];
      end
      expected_results.push_back(r);
      results_predicted++;
   endtask

   // advance the model by one accepted byte
   task automatic predict_byte(input logic [7:0] b, input logic eof);
      logic [31:0] acc;
      logic [15:0] hi16;
      logic [31:0] hend;
      logic [31:0] pos32;
      logic        topdown;
      logic        decided;
      error_code_type code;
      decided = 1'b0;
      code = ERR_OK;
      if (!parse_done) begin
         acc = {b, shift_acc[31:8]};
         hi16 = acc[31:16];
         shift_acc = acc;
         pos32 = {24'h0, parse_pos};
         if (parse_pos == POS_SIG_B) begin
            if (b != SIG_B) begin
               decided = 1'b1;
               code = ERR_SIGNATURE;
            end
         end else if (parse_pos == POS_SIG_M) begin
            if (b != SIG_M) begin
               decided = 1'b1;
               code = ERR_SIGNATURE;
            end
         end else if (parse_pos == POS_FILE_SIZE) begin
            cap_file_size = acc;
         end else if (parse_pos == POS_RSVD_1 || parse_pos == POS_RSVD_2) begin
            if (hi16 != 16'h0) begin
               decided = 1'b1;
               code = ERR_RESERVED;
            end
         end else if (parse_pos == POS_OFFSET) begin
            cap_offset = acc;
         end else if (parse_pos == POS_HDR_SIZE) begin
            hdr_size = acc;
            if (acc != HDR_SIZE_CORE && acc != HDR_SIZE_INFO && acc != HDR_SIZE_V4 &&
                acc != HDR_SIZE_V5) begin
               decided = 1'b1;
               code = ERR_HEADER_SIZE;
            end
         end else if (parse_pos > POS_HDR_SIZE) begin
            hend = FILE_HDR_SIZE + hdr_size;
            if (hdr_size == HDR_SIZE_CORE) begin
               if (parse_pos == POS_C_WIDTH) cap_width = {16'h0, hi16};
               else if (parse_pos == POS_C_HEIGHT) cap_height = {16'h0, hi16};
               else if (parse_pos == POS_C_PLANES) begin
                  if (hi16 != PLANES_ONE) begin
                     decided = 1'b1;
                     code = ERR_PLANES;
                  end
               end else if (parse_pos == POS_C_BPP) cap_bpp = hi16;
            end else begin
               if (parse_pos == POS_I_WIDTH) cap_width = acc;
               else if (parse_pos == POS_I_HEIGHT) cap_height = acc;
               else if (parse_pos == POS_I_PLANES) begin
                  if (hi16 != PLANES_ONE) begin
                     decided = 1'b1;
                     code = ERR_PLANES;
                  end
               end else if (parse_pos == POS_I_BPP) cap_bpp = hi16;
               else if (parse_pos == POS_I_COMP) begin
                  cap_comp = acc;
                  if (!(acc <= 32'd5 || acc == 32'd11 || acc == 32'd12 || acc == 32'd13)) begin
                     decided = 1'b1;
                     code = ERR_COMPRESSION;
                  end
               end
            end
            if (!decided) begin
               if (pos32 == hend - 1) begin
                  // checks made once the whole info header is in
                  topdown = (cap_height == 32'h0) || cap_height[31];
                  decided = 1'b1;
                  if (topdown && hdr_size > HDR_SIZE_CORE && cap_comp != COMP_RGB &&
                      cap_comp != COMP_BITFIELDS) code = ERR_TOPDOWN;
                  else if (cap_width == 32'h0) code = ERR_WIDTH;
                  else if (cap_offset < hend) code = ERR_OFFSET;
                  else if (cap_offset == hend) code = ERR_OK;
                  else if (cap_offset - hend < MIN_GAP) code = ERR_GAP;
                  else decided = 1'b0;
               end else if (pos32 >= hend && pos32 < hend + 3) begin
                  pal_bytes[pos32 - hend] = b;
               end else if (pos32 == hend + 3) begin
                  decided = 1'b1;
                  code = (b != 8'h0) ? ERR_QUAD : ERR_OK;
               end
            end
         end
         if (decided) begin
            queue_result(code);
            parse_done = 1'b1;
         end else begin
            parse_pos = parse_pos + 8'd1;
         end
      end
      if (eof) begin
         if (!parse_done) queue_result(ERR_TRUNCATED);
         clear_parser_model();
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eof);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= eof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      predict_byte(b, eof);
   endtask

   task automatic send_file(input int count);
      int n;
      n = (count > file_bytes.size()) ? file_bytes.size() : count;
      if (n < 1) n = 1;
      for (int i = 0; i < n; i++) send_byte(file_bytes[i], i == n - 1);
   endtask

   task automatic put_le(input logic [31:0] value, input int nbytes);
      for (int i = 0; i < nbytes; i++) file_bytes.push_back(value[8*i +: 8]);
   endtask

   task automatic assemble_bitmap(input logic [31:0] hsize, width, height,
                                  input logic [15:0] planes, bpp,
                                  input logic [31:0] comp, offset, fsize, quad,
                                  input int tail);
      logic [31:0] hend;
      logic        known_size;
      int          quad_len;
      file_bytes.delete();
      file_bytes.push_back(SIG_B);
      file_bytes.push_back(SIG_M);
      put_le(fsize, 4);
      put_le(32'h0, 2);
      put_le(32'h0, 2);
      put_le(offset, 4);
      put_le(hsize, 4);
      hend = FILE_HDR_SIZE + hsize;
      known_size = (hsize == HDR_SIZE_CORE || hsize == HDR_SIZE_INFO ||
                    hsize == HDR_SIZE_V4 || hsize == HDR_SIZE_V5);
      quad_len = 0;
      if (hsize == HDR_SIZE_CORE) begin
         put_le(width, 2);
         put_le(height, 2);
         put_le(planes, 2);
         put_le(bpp, 2);
      end else if (known_size) begin
         put_le(width, 4);
         put_le(height, 4);
         put_le(planes, 2);
         put_le(bpp, 2);
         put_le(comp, 4);
         // colour masks and the rest of the larger headers
         for (int i = 20; i < hsize; i++) file_bytes.push_back(8'($urandom_range(255)));
      end
      if (known_size && offset >= hend) quad_len = (offset - hend > 4) ? 4 : offset - hend;
      for (int i = 0; i < quad_len; i++) file_bytes.push_back(quad[8*i +: 8]);
      repeat (tail) file_bytes.push_back(8'($urandom_range(255)));
   endtask

   task automatic send_bitmap(input logic [31:0] hsize, width, height,
                              input logic [15:0] planes, bpp,
                              input logic [31:0] comp, offset, fsize, quad,
                              input int tail);
      assemble_bitmap(hsize, width, height, planes, bpp, comp, offset, fsize, quad, tail);
      send_file(file_bytes.size());
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_valid_headers();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      send_bitmap(HDR_SIZE_CORE, 32'hffff, 32'hffff, PLANES_ONE, 16'hffff, COMP_RGB,
                  FILE_HDR_SIZE + HDR_SIZE_CORE, 32'h0, 32'h0, 2);
      send_bitmap(HDR_SIZE_INFO, 32'h7fffffff, 32'h80000000, PLANES_ONE, 16'd32,
                  COMP_BITFIELDS, FILE_HDR_SIZE + HDR_SIZE_INFO + 12, 32'hffffffff,
                  32'h00ffffff, 3);
      send_bitmap(HDR_SIZE_INFO, 32'd1, 32'd1, PLANES_ONE, 16'd0, COMP_RGB,
                  FILE_HDR_SIZE + HDR_SIZE_INFO + 4, 32'd1, 32'h00010203, 0);
      send_bitmap(HDR_SIZE_V4, 32'h80000000, 32'h7fffffff, PLANES_ONE, 16'd24, 32'd4,
                  FILE_HDR_SIZE + HDR_SIZE_V4, 32'h12345678, 32'h0, 1);
      send_bitmap(HDR_SIZE_V5, 32'hfffffffe, 32'h00000100, PLANES_ONE, 16'd8, 32'd13,
                  32'hffffffff, 32'h80000000, 32'h00aa55cc, 2);
   endtask

   task automatic test_file_header_errors();
      sender_idle_pct = 80;
      receiver_stall_pct = 80;
      assemble_bitmap(HDR_SIZE_CORE, 32'd4, 32'd4, PLANES_ONE, 16'd8, COMP_RGB,
                      FILE_HDR_SIZE + HDR_SIZE_CORE, 32'd100, 32'h0, 0);
      file_bytes[0] = 8'h41;
      send_file(file_bytes.size());
      assemble_bitmap(HDR_SIZE_CORE, 32'd4, 32'd4, PLANES_ONE, 16'd8, COMP_RGB,
                      FILE_HDR_SIZE + HDR_SIZE_CORE, 32'd100, 32'h0, 0);
      file_bytes[1] = 8'h4e;
      send_file(file_bytes.size());
      // bad signature on a one-byte file
      file_bytes.delete();
      file_bytes.push_back(8'hff);
      send_file(1);
      assemble_bitmap(HDR_SIZE_CORE, 32'd4, 32'd4, PLANES_ONE, 16'd8, COMP_RGB,
                      FILE_HDR_SIZE + HDR_SIZE_CORE, 32'd100, 32'h0, 0);
      file_bytes[7] = 8'h80;
      send_file(file_bytes.size());
      assemble_bitmap(HDR_SIZE_CORE, 32'd4, 32'd4, PLANES_ONE, 16'd8, COMP_RGB,
                      FILE_HDR_SIZE + HDR_SIZE_CORE, 32'd100, 32'h0, 0);
      file_bytes[8] = 8'h01;
      send_file(file_bytes.size());
      send_bitmap(32'd41, 32'd4, 32'd4, PLANES_ONE, 16'd8, COMP_RGB, 32'd60, 32'd0, 32'h0, 4);
      send_bitmap(32'h8000000c, 32'd4, 32'd4, PLANES_ONE, 16'd8, COMP_RGB, 32'd60, 32'd0,
                  32'h0, 4);
   endtask

   task automatic test_header_field_errors();
      sender_idle_pct = 0;
      receiver_stall_pct = 80;
      send_bitmap(HDR_SIZE_CORE, 32'd4, 32'd4, 16'd0, 16'd8, COMP_RGB,
                  FILE_HDR_SIZE + HDR_SIZE_CORE, 32'd1, 32'h0, 2);
      send_bitmap(HDR_SIZE_INFO, 32'd4, 32'd4, 16'h8001, 16'd8, COMP_RGB,
                  FILE_HDR_SIZE + HDR_SIZE_INFO, 32'd1, 32'h0, 2);
      send_bitmap(HDR_SIZE_INFO, 32'd4, 32'd4, PLANES_ONE, 16'd8, 32'd6,
                  FILE_HDR_SIZE + HDR_SIZE_INFO, 32'd1, 32'h0, 2);
      send_bitmap(HDR_SIZE_V5, 32'd4, 32'd4, PLANES_ONE, 16'd8, 32'hffffffff,
                  FILE_HDR_SIZE + HDR_SIZE_V5, 32'd1, 32'h0, 2);
      // top-down height with a compression that does not allow it
      send_bitmap(HDR_SIZE_INFO, 32'd4, 32'd0, PLANES_ONE, 16'd8, 32'd1,
                  FILE_HDR_SIZE + HDR_SIZE_INFO, 32'd1, 32'h0, 2);
      send_bitmap(HDR_SIZE_V4, 32'd4, 32'hfffffffb, PLANES_ONE, 16'd8, 32'd12,
                  FILE_HDR_SIZE + HDR_SIZE_V4, 32'd1, 32'h0, 2);
      // zero height is allowed for a core header
      send_bitmap(HDR_SIZE_CORE, 32'd4, 32'd0, PLANES_ONE, 16'd1, COMP_RGB,
                  FILE_HDR_SIZE + HDR_SIZE_CORE, 32'd1, 32'h0, 2);
   endtask

   task automatic test_layout_errors();
      sender_idle_pct = 80;
      receiver_stall_pct = 0;
      send_bitmap(HDR_SIZE_INFO, 32'd0, 32'd4, PLANES_ONE, 16'd8, COMP_RGB,
                  FILE_HDR_SIZE + HDR_SIZE_INFO, 32'd1, 32'h0, 1);
      send_bitmap(HDR_SIZE_CORE, 32'h0, 32'd4, PLANES_ONE, 16'd8, COMP_RGB,
                  FILE_HDR_SIZE + HDR_SIZE_CORE, 32'd1, 32'h0, 1);
      send_bitmap(HDR_SIZE_INFO, 32'd4, 32'd4, PLANES_ONE, 16'd8, COMP_RGB,
                  FILE_HDR_SIZE + HDR_SIZE_INFO - 1, 32'd1, 32'h0, 1);
      send_bitmap(HDR_SIZE_CORE, 32'd4, 32'd4, PLANES_ONE, 16'd8, COMP_RGB, 32'd0, 32'd1,
                  32'h0, 1);
      send_bitmap(HDR_SIZE_CORE, 32'd4, 32'd4, PLANES_ONE, 16'd8, COMP_RGB,
                  FILE_HDR_SIZE + HDR_SIZE_CORE + 1, 32'd1, 32'h0, 1);
      send_bitmap(HDR_SIZE_INFO, 32'd4, 32'd4, PLANES_ONE, 16'd8, COMP_RGB,
                  FILE_HDR_SIZE + HDR_SIZE_INFO + 3, 32'd1, 32'h0, 1);
      send_bitmap(HDR_SIZE_CORE, 32'd4, 32'd4, PLANES_ONE, 16'd8, COMP_RGB,
                  FILE_HDR_SIZE + HDR_SIZE_CORE + 4, 32'd1, 32'hff000000, 1);
      // bytes after the result are ignored until end of file
      send_bitmap(HDR_SIZE_CORE, 32'd7, 32'd3, PLANES_ONE, 16'd4, COMP_RGB,
                  FILE_HDR_SIZE + HDR_SIZE_CORE + 5, 32'd1, 32'h00ffeedd, 10);
   endtask

   task automatic test_truncation();
      sender_idle_pct = 6;
      receiver_stall_pct = 6;
      assemble_bitmap(HDR_SIZE_CORE, 32'd4, 32'd4, PLANES_ONE, 16'd8, COMP_RGB,
                      FILE_HDR_SIZE + HDR_SIZE_CORE + 4, 32'd1, 32'h00112233, 2);
      send_file(1);
      send_file(20);
      // end of file on the third palette byte, then on the fourth
      send_file(29);
      send_file(30);
      assemble_bitmap(HDR_SIZE_CORE, 32'd4, 32'd4, PLANES_ONE, 16'd8, COMP_RGB,
                      FILE_HDR_SIZE + HDR_SIZE_CORE, 32'd1, 32'h0, 2);
      send_file(26);
      assemble_bitmap(HDR_SIZE_V5, 32'd4, 32'd4, PLANES_ONE, 16'd8, COMP_RGB,
                      FILE_HDR_SIZE + HDR_SIZE_V5, 32'd1, 32'h0, 2);
      send_file(100);
   endtask

   task automatic test_random_files(input int sender_pct, input int receiver_pct,
                                    input int byte_goal, input int result_goal);
      int             start_bytes;
      int             start_results;
      int             pick;
      int             keep;
      int             n;
      fault_kind_type fault;
      logic [31:0]    hsize, width, height, comp, offset, fsize, quad, hend;
      logic [15:0]    planes, bpp;
      sender_idle_pct = sender_pct;
      receiver_stall_pct = receiver_pct;
      start_bytes = bytes_sent;
      start_results = results_predicted;
      while (bytes_sent - start_bytes < byte_goal ||
             results_predicted - start_results < result_goal) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            // short runs of junk
            file_bytes.delete();
            n = $urandom_range(24, 1);
            repeat (n) file_bytes.push_back(8'($urandom_range(255)));
            if ($urandom_range(1)) file_bytes[0] = SIG_B;
            send_file(n);
         end else begin
            pick = $urandom_range(99);
            hsize = (pick < 55) ? HDR_SIZE_CORE : (pick < 80) ? HDR_SIZE_INFO :
                    (pick < 90) ? HDR_SIZE_V4 : HDR_SIZE_V5;
            hend = FILE_HDR_SIZE + hsize;
            width = $urandom;
            if (width == 32'h0) width = 32'd1;
            height = $urandom;
            if (hsize == HDR_SIZE_CORE) begin
               width[31:16] = 16'h0;
               height[31:16] = 16'h0;
            end else if ($urandom_range(3) != 0) begin
               height[31] = 1'b0;
            end
            planes = PLANES_ONE;
            case ($urandom_range(7))
               0: bpp = 16'd1;
               1: bpp = 16'd4;
               2: bpp = 16'd8;
               3: bpp = 16'd24;
               4: bpp = 16'd32;
               default: bpp = 16'($urandom);
            endcase
            pick = $urandom_range(8);
            comp = (pick < 3) ? COMP_RGB : (pick < 5) ? COMP_BITFIELDS :
                   (pick == 5) ? 32'($urandom_range(5)) : 32'($urandom_range(13, 11));
            pick = $urandom_range(99);
            if (pick < 40) offset = hend;
            else if (pick < 90) offset = hend + 4 + $urandom_range(60);
            else offset = $urandom_range(32'hffffffff, hend + 4);
            fsize = ($urandom_range(9) == 0) ? 32'h0 : $urandom;
            quad = {8'h00, 24'($urandom)};
            keep = 1 << 30;
            fault = FAULT_COUNT;
            if ($urandom_range(99) < 30) fault = fault_kind_type'($urandom_range(FAULT_COUNT - 1));
            case (fault)
               FAULT_HEADER_SIZE: begin
                  hsize = ($urandom_range(3) == 0) ? $urandom : $urandom_range(255);
                  if (hsize == HDR_SIZE_CORE || hsize == HDR_SIZE_INFO ||
                      hsize == HDR_SIZE_V4 || hsize == HDR_SIZE_V5) hsize = hsize + 1;
               end
               FAULT_PLANES: begin
                  planes = 16'($urandom);
                  if (planes == PLANES_ONE) planes = 16'h0;
               end
               FAULT_TOPDOWN: begin
                  height = ($urandom_range(1)) ? 32'h0 : ($urandom | 32'h80000000);
                  comp = ($urandom_range(1)) ? 32'($urandom_range(2, 1)) :
                         32'($urandom_range(13, 11));
               end
               FAULT_WIDTH: width = 32'h0;
               FAULT_OFFSET: offset = $urandom_range(hend - 1, 0);
               FAULT_GAP: offset = hend + $urandom_range(3, 1);
               FAULT_QUAD: quad[31:24] = 8'($urandom_range(255, 1));
               FAULT_COMPRESSION: begin
                  comp = $urandom;
                  if (comp <= 32'd5 || comp == 32'd11 || comp == 32'd12 || comp == 32'd13)
                     comp = 32'd6;
               end
               default: ;
            endcase
            assemble_bitmap(hsize, width, height, planes, bpp, comp, offset, fsize, quad,
                            $urandom_range(3));
            case (fault)
               FAULT_SIGNATURE: file_bytes[$urandom_range(1)] ^= 8'($urandom_range(255, 1));
               FAULT_RESERVED: file_bytes[$urandom_range(9, 6)] = 8'($urandom_range(255, 1));
               FAULT_TRUNCATE: keep = $urandom_range(file_bytes.size() - 1, 1);
               default: ;
            endcase
            send_file(keep);
         end
      end
   endtask

   task automatic compare_field(input string field_name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", field_name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin : check_results
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(result_type)-1:0];
         if (expected_results.size() == 0) begin
            $error("result item with none expected: error_code %0d", got.error_code);
            failures++;
         end else begin
            want = expected_results.pop_front();
            compare_field("error_code", want.error_code, got.error_code);
            compare_field("header_kind", want.header_kind, got.header_kind);
            compare_field("image_width", want.image_width, got.image_width);
            compare_field("image_height", want.image_height, got.image_height);
            compare_field("bits_per_pixel", want.bits_per_pixel, got.bits_per_pixel);
            compare_field("compression_code", want.compression_code, got.compression_code);
            compare_field("pixel_offset", want.pixel_offset, got.pixel_offset);
            compare_field("declared_file_size", want.declared_file_size,
                          got.declared_file_size);
            compare_field("zero_size_warning", want.zero_size_warning, got.zero_size_warning);
            compare_field("palette_red", want.palette_red, got.palette_red);
            compare_field("palette_green", want.palette_green, got.palette_green);
            compare_field("palette_blue", want.palette_blue, got.palette_blue);
         end
      end
   end

   initial begin
      clear_parser_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_valid_headers();
      test_file_header_errors();
      wait_for_results();
      test_header_field_errors();
      test_layout_errors();
      test_truncation();
      test_random_files(0, 0, 0, 1);
      test_random_files(80, 0, 0, 1);
      test_random_files(0, 80, 0, 1);
      test_random_files(6, 6, 0, 1);
      wait_for_results();
      repeat (20) @(posedge clock);
      if (expected_results.size() != 0) failures++;
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
